/* hdl/bitmap_handle_pool_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the handle pool.
// These expect a clock named clk and an active-low reset named arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef BITMAP_HANDLE_POOL_UNIT_DEFINES_SVH
`define BITMAP_HANDLE_POOL_UNIT_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define BHP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BHP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/bhp_pkg.sv */
// ---------------------------------------------------------------------------
// bhp_pkg
// Shared types and constants of the handle pool.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bhp_pkg;

	// Fixed port widths
	localparam int STATUS_W    = 3;
	localparam int HANDLE_W    = 64;
	localparam int SLOT_OUT_W  = 6;
	localparam int COUNT_OUT_W = 7;
	localparam int LIMIT_W     = 7;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	// Slots examined per scan cycle
	localparam int GROUP_BITS = 32;

	localparam logic CMD_OBTAIN  = 1'b0;
	localparam logic CMD_DEPOSIT = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_TAKEN     = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_DEPOSITED = 3'd2,
		ST_FULL      = 3'd3,
		ST_NULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_READ
	} state_t;

endpackage

`default_nettype wire

/* hdl/bitmap_handle_pool_unit.sv */
// ---------------------------------------------------------------------------
// bitmap_handle_pool_unit
// Pool of reusable handles: slot RAM plus an occupancy bitmap in flops.
// ---------------------------------------------------------------------------
// Sequence: a null deposit is answered straight from idle; otherwise the 32-slot
//   groups are scanned in turn up to a match or the last group; an obtain adds a RAM read.
// Flow: busy covers the scan and read; the next start is taken in the cycle
//   done shows, so one command is in flight at a time. Done cannot be stalled.
// Reset: bitmap and held count clear at once, limit returns to 64; the slot RAM
//   is not cleared (an entry is only read after it has been written).
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_handle_pool_unit_defines.svh"

module bitmap_handle_pool_unit #(
	parameter int CAPACITY    = 64,
	parameter int HANDLE_BITS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// command side
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              cmd,
	input  wire logic [bhp_pkg::HANDLE_W-1:0]      handle_in,
	// configuration: capacity_limit
	input  wire logic                              cfg_we,
	input  wire logic [bhp_pkg::LIMIT_W-1:0]       cfg_data,
	// result side
	output logic                                   done,
	output logic [bhp_pkg::STATUS_W-1:0]           status,
	output logic [bhp_pkg::HANDLE_W-1:0]           handle_out,
	output logic [bhp_pkg::SLOT_OUT_W-1:0]         slot_used,
	output logic [bhp_pkg::COUNT_OUT_W-1:0]        available_count
);

	import bhp_pkg::*;

	// Geometry. Small pools scan as a single narrower group.
	localparam int GW  = (CAPACITY < GROUP_BITS) ? CAPACITY : GROUP_BITS;
	localparam int NG  = (CAPACITY + GW - 1) / GW;
	localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
	localparam int PW  = (GW > 1) ? $clog2(GW) : 1;
	localparam int SW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int IW  = $clog2(NG * GW + 1);
	localparam int XW  = (IW > LIMIT_W) ? IW : LIMIT_W;

	// Control state
	state_t                 state_q, state_d;
	logic                   cmd_q;
	logic [HANDLE_BITS-1:0] hnd_q;
	logic [GIW-1:0]         grp_q;
	logic [SW-1:0]          fslot_q;
	logic [NG-1:0][GW-1:0]  occ_q;
	logic [CW-1:0]          held_q;
	logic [LIMIT_W-1:0]     cap_q;

	// Result registers
	logic                   done_q;
	status_t                status_q;
	logic [HANDLE_BITS-1:0] hout_q;
	logic [SW-1:0]          slot_q;

	// RAM
	logic                   ram_we, ram_re;
	logic [HANDLE_BITS-1:0] ram_rdata;

	// Scan datapath
	logic                   accept;
	logic [HANDLE_BITS-1:0] hnd_in_m;
	logic                   is_null;
	logic [XW-1:0]          lim_x;
	logic [GW-1:0]          grp_word;
	logic [GW-1:0]          in_use;
	logic [GW-1:0]          cand;
	logic                   found;
	logic [PW-1:0]          pos;
	logic [SW-1:0]          slot;
	logic                   last_grp;

	// Comb control outputs
	logic                   fin_d;
	status_t                status_d;
	logic [SW-1:0]          slot_d;
	logic                   set_bit, clr_bit;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign hnd_in_m = handle_in[HANDLE_BITS-1:0];
	assign is_null  = (hnd_in_m == '0);
	assign grp_word = occ_q[grp_q];
	assign last_grp = (grp_q == GIW'(NG - 1));

	// Slots in use: a limit of zero means one, anything above the pool saturates.
	always_comb begin
		logic [XW-1:0] cfg_x;
		cfg_x = XW'(cap_q);
		if (cfg_x == '0) begin
			lim_x = XW'(1);
		end else if (cfg_x > XW'(CAPACITY)) begin
			lim_x = XW'(CAPACITY);
		end else begin
			lim_x = cfg_x;
		end
	end

	// Mask of slots in the current group that deposits may use
	always_comb begin
		logic [XW-1:0] base_x;
		base_x = XW'(grp_q) * XW'(GW);
		for (int i = 0; i < GW; i++) begin
			in_use[i] = (XW'(base_x + XW'(i)) < lim_x);
		end
	end

	// Obtain wants the lowest occupied slot, deposit the lowest free one
	assign cand  = (cmd_q == CMD_OBTAIN) ? grp_word : (~grp_word & in_use);
	assign found = |cand;

	always_comb begin
		pos = '0;
		for (int i = GW - 1; i >= 0; i--) begin
			if (cand[i]) begin
				pos = PW'(i);
			end
		end
	end

	assign slot = SW'(XW'(grp_q) * XW'(GW) + XW'(pos));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && !(cmd == CMD_DEPOSIT && is_null)) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (found && cmd_q == CMD_OBTAIN) begin
					state_d = S_READ;
				end else if (found || last_grp) begin
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		fin_d    = 1'b0;
		status_d = ST_EMPTY;
		slot_d   = '0;
		set_bit  = 1'b0;
		clr_bit  = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd == CMD_DEPOSIT && is_null) begin
					fin_d    = 1'b1;
					status_d = ST_NULL;
				end
			end
			S_SCAN: begin
				if (found) begin
					slot_d = slot;
					if (cmd_q == CMD_OBTAIN) begin
						clr_bit = 1'b1;
						ram_re  = 1'b1;
					end else begin
						set_bit  = 1'b1;
						ram_we   = 1'b1;
						fin_d    = 1'b1;
						status_d = ST_DEPOSITED;
					end
				end else if (last_grp) begin
					fin_d    = 1'b1;
					status_d = (cmd_q == CMD_OBTAIN) ? ST_EMPTY : ST_FULL;
				end
			end
			S_READ: begin
				fin_d    = 1'b1;
				status_d = ST_TAKEN;
				slot_d   = fslot_q;
			end
			default: begin
				fin_d = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			held_q  <= '0;
			cap_q   <= LIMIT_RESET;
			done_q  <= 1'b0;
			grp_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= fin_d;
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (accept) begin
				grp_q <= '0;
			end else if (state_q == S_SCAN && !found && !last_grp) begin
				grp_q <= grp_q + GIW'(1);
			end
			if (set_bit) begin
				occ_q[grp_q][pos] <= 1'b1;
				held_q            <= held_q + CW'(1);
			end else if (clr_bit) begin
				occ_q[grp_q][pos] <= 1'b0;
				held_q            <= held_q - CW'(1);
			end
		end
	end

	// Command capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			hnd_q <= hnd_in_m;
		end
		if (clr_bit) begin
			fslot_q <= slot;
		end
		if (fin_d) begin
			status_q <= status_d;
			slot_q   <= slot_d;
			hout_q   <= (state_q == S_READ) ? ram_rdata : '0;
		end
	end

	bhp_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (HANDLE_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot),
		.wdata (hnd_q),
		.re    (ram_re),
		.raddr (slot),
		.rdata (ram_rdata)
	);

	assign done            = done_q;
	assign status          = status_q;
	assign handle_out      = HANDLE_W'(hout_q);
	assign slot_used       = SLOT_OUT_W'(slot_q);
	assign available_count = COUNT_OUT_W'(held_q);

	// Held count always tracks the bitmap population
	`BHP_ASSERT_SAME(a_held_matches_map, 1'b1, $countones(occ_q) == int'(held_q), "held count out of step with bitmap")
	// A handle handed out is never null: only non-null words are stored
	`BHP_ASSERT_SAME(a_taken_nonnull, done_q && status_q == ST_TAKEN, hout_q != '0, "null handle taken from pool")
	// The RAM read always completes into a result
	`BHP_ASSERT_NEXT(a_read_finishes, state_q == S_READ, done_q, "slot read gave no result")
	// Result status is always one of the five codes
	`BHP_ASSERT_SAME(a_status_legal, done_q, status_q <= ST_NULL, "result status out of range")

endmodule

`default_nettype wire

/* hdl/bhp_ram.sv */
// ---------------------------------------------------------------------------
// bhp_ram
// Handle store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bhp_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sim/tb_bitmap_handle_pool_unit.sv */
// ---------------------------------------------------------------------------
// tb_bitmap_handle_pool_unit
// Self-checking bench for the handle pool. Directed tests cover empty obtain,
// null and full rejection, extreme handles and limit edge values. Random
// blocks then follow under several limits and obtain/deposit mixes. Every
// reply word is checked field by field against an in-bench model of the pool.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitmap_handle_pool_unit;

	import bhp_pkg::*;

	localparam int POOL_SLOTS  = 64;
	localparam int BLOCK_WORDS = 60;
	localparam int DRAIN_PAUSE = 8;      // scan (2 groups) + RAM read, with margin

	// reply word as the block should show it
	typedef struct {
		status_t                 status;
		logic [HANDLE_W-1:0]     handle;
		logic [SLOT_OUT_W-1:0]   slot;
		logic [COUNT_OUT_W-1:0]  count;
	} pool_reply_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    cmd;
	logic [HANDLE_W-1:0]     handle_in;
	logic                    cfg_we;
	logic [LIMIT_W-1:0]      cfg_data;
	logic                    done;
	logic [STATUS_W-1:0]     status;
	logic [HANDLE_W-1:0]     handle_out;
	logic [SLOT_OUT_W-1:0]   slot_used;
	logic [COUNT_OUT_W-1:0]  available_count;

	// model of the pool contents
	logic [POOL_SLOTS-1:0]   pool_occ;
	logic [HANDLE_W-1:0]     pool_store [POOL_SLOTS];
	int                      pool_held;
	logic [LIMIT_W-1:0]      pool_limit;

	pool_reply_t             reply_queue [$];
	int                      errors;
	int                      send_idle_pct;

	bitmap_handle_pool_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.handle_in       (handle_in),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.done            (done),
		.status          (status),
		.handle_out      (handle_out),
		.slot_used       (slot_used),
		.available_count (available_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Work out the reply to one accepted word and move the model on.
	// Obtain takes the lowest occupied slot wherever it is, even above the
	// limit; deposit only looks at free slots below the (clamped) limit.
	function automatic pool_reply_t predict_reply(logic c, logic [HANDLE_W-1:0] h);
		pool_reply_t r;
		int          s;
		int          lim;
		bit          found;
		r.status = ST_EMPTY;
		r.handle = '0;
		r.slot   = '0;
		found    = 1'b0;
		if (c == CMD_OBTAIN) begin
			for (s = 0; s < POOL_SLOTS; s++) begin
				if (!found && pool_occ[s]) begin
					found       = 1'b1;
					r.handle    = pool_store[s];
					r.slot      = s[SLOT_OUT_W-1:0];
					r.status    = ST_TAKEN;
					pool_occ[s] = 1'b0;
					if (pool_held > 0)
						pool_held--;
				end
			end
		end else begin
			// limit of zero means one slot; anything past the pool saturates
			lim = pool_limit;
			if (lim == 0)
				lim = 1;
			if (lim > POOL_SLOTS)
				lim = POOL_SLOTS;
			if (h == '0) begin
				// null wins over full
				r.status = ST_NULL;
			end else begin
				r.status = ST_FULL;
				for (s = 0; s < lim; s++) begin
					if (!found && !pool_occ[s]) begin
						found         = 1'b1;
						pool_store[s] = h;
						pool_occ[s]   = 1'b1;
						pool_held++;
						r.slot        = s[SLOT_OUT_W-1:0];
						r.status      = ST_DEPOSITED;
					end
				end
			end
		end
		r.count = pool_held[COUNT_OUT_W-1:0];
		return r;
	endfunction

	// Handle mix: mostly full-width random, with null, all-ones and one-hot
	// words thrown in so the edges are hit often.
	function automatic logic [HANDLE_W-1:0] rand_handle();
		int pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return '0;
		else if (pick < 8)
			return '1;
		else if (pick < 12)
			return 64'd1 << $urandom_range(HANDLE_W-1);
		else
			return {$urandom, $urandom};
	endfunction

	// Offer one command word; held on start until the block takes it.
	// With a chance of send_idle_pct, an idle gap of random length goes in first,
	// so idle cycles land on every phase of the scan.
	task automatic send_word(logic c, logic [HANDLE_W-1:0] h);
		if ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		start     <= 1'b1;
		cmd       <= c;
		handle_in <= h;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		reply_queue.push_back(predict_reply(c, h));
	endtask

	// Drop start, let every outstanding reply arrive, then sit out the latency.
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (reply_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
	endtask

	// Limit register is only touched once the block is idle.
	task automatic write_limit(logic [LIMIT_W-1:0] v);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we   <= 1'b0;
		pool_limit = v;
	endtask

	// ---- directed tests ----

	task automatic test_obtain_empty();
		send_word(CMD_OBTAIN, {$urandom, $urandom});
	endtask

	task automatic test_null_deposit();
		send_word(CMD_DEPOSIT, '0);
	endtask

	task automatic test_handle_extremes();
		send_word(CMD_DEPOSIT, '1);
		send_word(CMD_DEPOSIT, 64'd1);
		send_word(CMD_DEPOSIT, 64'h8000_0000_0000_0000);
		repeat (3) send_word(CMD_OBTAIN, '0);
	endtask

	// Zero limit behaves as a single slot; null with a full pool is still null.
	task automatic test_limit_zero();
		write_limit('0);
		send_word(CMD_DEPOSIT, 64'h0123_4567_89ab_cdef);
		send_word(CMD_DEPOSIT, 64'hfedc_ba98_7654_3210);
		send_word(CMD_DEPOSIT, '0);
		send_word(CMD_OBTAIN, '0);
	endtask

	// Lower the limit under occupied slots: held handles still come out,
	// deposits only reuse free slots under the new limit.
	task automatic test_limit_lowered();
		int i;
		write_limit(LIMIT_RESET);
		for (i = 0; i < 4; i++)
			send_word(CMD_DEPOSIT, {$urandom, $urandom} | 64'd1);
		write_limit(7'd2);
		send_word(CMD_DEPOSIT, {$urandom, $urandom} | 64'd1);
		send_word(CMD_OBTAIN, '0);
		send_word(CMD_DEPOSIT, {$urandom, $urandom} | 64'd1);
		send_word(CMD_OBTAIN, '0);
	endtask

	// ---- random tests ----

	// One block of random words under one limit and one deposit share.
	task automatic run_random_block(logic [LIMIT_W-1:0] lim, int dep_pct);
		int i;
		write_limit(lim);
		for (i = 0; i < BLOCK_WORDS; i++) begin
			if ($urandom_range(99) < dep_pct)
				send_word(CMD_DEPOSIT, rand_handle());
			else
				send_word(CMD_OBTAIN, rand_handle());
		end
	endtask

	// Eight blocks; the offset rotates which limit meets which mix, so the
	// high deposit shares also meet the wide limits and fill the whole pool.
	task automatic run_random_phase(int offset);
		int               blk;
		logic [LIMIT_W-1:0] lim;
		int               dep;
		for (blk = 0; blk < 8; blk++) begin
			case ((blk + offset) % 8)
				0: lim = 7'd1;
				1: lim = 7'd2;
				2: lim = 7'd127;
				3: lim = 7'd64;
				4: lim = 7'd63;
				5: lim = 7'd65;
				6: lim = 7'd0;
				default: lim = LIMIT_W'($urandom_range(127));
			endcase
			case (blk)
				0: dep = 70;
				1: dep = 50;
				2: dep = 90;
				3: dep = 40;
				4: dep = 90;
				5: dep = 90;
				6: dep = 60;
				default: dep = 20;
			endcase
			run_random_block(lim, dep);
		end
	endtask

	task automatic test_random_sender_sparse();
		send_idle_pct = 22;
		run_random_phase(0);
	endtask

	task automatic test_random_sender_lazy();
		send_idle_pct = 68;
		run_random_phase(3);
	endtask

	task automatic test_random_back_to_back();
		send_idle_pct = 0;
		run_random_phase(5);
	endtask

	// Reply checker: each done strobe pops the oldest expected word.
	always @(posedge clk) begin
		pool_reply_t exp_r;
		if (arst_n && done) begin
			if (reply_queue.size() == 0) begin
				errors++;
				$display("%0t: reply word with none expected, status %0d handle %h",
					$time, status, handle_out);
			end else begin
				exp_r = reply_queue.pop_front();
				if (status !== exp_r.status) begin
					errors++;
					$display("%0t: status expected %0d got %0d", $time, exp_r.status, status);
				end
				if (handle_out !== exp_r.handle) begin
					errors++;
					$display("%0t: handle_out expected %h got %h", $time, exp_r.handle,
						handle_out);
				end
				if (slot_used !== exp_r.slot) begin
					errors++;
					$display("%0t: slot_used expected %0d got %0d", $time, exp_r.slot,
						slot_used);
				end
				if (available_count !== exp_r.count) begin
					errors++;
					$display("%0t: available_count expected %0d got %0d", $time,
						exp_r.count, available_count);
				end
			end
		end
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		cmd           = CMD_OBTAIN;
		handle_in     = '0;
		cfg_we        = 1'b0;
		cfg_data      = '0;
		errors        = 0;
		send_idle_pct = 22;
		pool_occ      = '0;
		pool_held     = 0;
		pool_limit    = LIMIT_RESET;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_obtain_empty();
		test_null_deposit();
		test_handle_extremes();
		test_limit_zero();
		test_limit_lowered();
		test_random_sender_sparse();
		test_random_sender_lazy();
		test_random_back_to_back();

		wait_drained();
		if (errors == 0 && reply_queue.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
